// ===== rtl/dhkt_pkg.sv =====
// Shared types, constants and helpers for the double hash key table.
package dhkt_pkg;

  localparam int MaxLog2 = 8;
  localparam int HashBits = 32;
  localparam int Slots = 1 << MaxLog2;
  localparam int IdxW = MaxLog2;
  localparam int CntW = MaxLog2 + 1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TAG_FREE = 2'd0,
    TAG_LIVE = 2'd1,
    TAG_TOMB = 2'd2
  } tag_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_EVAL,
    S_FINISH
  } fsm_t;

  localparam logic [0:0] REG_TABLE_LOG2 = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdxW-1:0] slot_index;
    logic [31:0]     value_out;
    logic [CntW-1:0] live_count;
    logic [CntW-1:0] tombstone_count;
  } out_word_t;

  // Clamp the written capacity code to the supported range.
  function automatic logic [3:0] clamp_log2(logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd2) r = 4'd2;
    if (v > 4'(MaxLog2)) r = 4'(MaxLog2);
    return r;
  endfunction

endpackage

// ===== rtl/double_hash_key_table.sv =====
// Top level of the double hash key table: probe sequencer and slot memories.
// Each probe is a memory read, then a compare and step; a whole table scan of
// 2^L probes bounds an item, and an add that found neither key nor free slot
// reuses the first tombstone in a further finishing state. busy stays high
// while an item is worked on, and the result is shown for one cycle on
// out_valid; the receiver cannot stall. After reset and after each write of
// table_log2 a clearing pass over all 256 slots resets the tag and collision
// memory, during which busy is high.
module double_hash_key_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  dhkt_pkg::in_word_t        in_word,
  output logic                      out_valid,
  output dhkt_pkg::out_word_t       out_word,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import dhkt_pkg::*;

  // Slot memories: key/value and tag/collision, one read and one write port.
  logic [63:0] kv_mem [Slots];
  logic [2:0]  tc_mem [Slots];
  logic [63:0] kv_rd_r;
  logic [2:0]  tc_rd_r;

  fsm_t            state_r, state_nxt;
  in_word_t        item_r, item_nxt;
  logic [3:0]      log2_r, log2_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt, step_r, step_nxt, tomb_r, tomb_nxt;
  logic            have_tomb_r, have_tomb_nxt;
  logic [CntW-1:0] probes_r, probes_nxt, live_r, live_nxt, tombs_r, tombs_nxt;
  logic            ov_r, ov_nxt;
  out_word_t       ow_r, ow_nxt;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            kv_we, tc_we;
  logic [IdxW-1:0] kv_wa, tc_wa;
  logic [63:0]     kv_wd;
  logic [2:0]      tc_wd;

  logic            cfg_wr;
  logic [3:0]      lg;
  logic [IdxW-1:0] mask;
  logic [CntW-1:0] cap;
  tag_t            tg;
  logic            coll;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == REG_TABLE_LOG2);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_LOG2) ? {28'd0, log2_r} : 32'd0;
  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

  assign lg   = clamp_log2(log2_r);
  assign mask = IdxW'((CntW'(1) << lg) - CntW'(1));
  assign cap  = CntW'(1) << lg;
  assign tg   = tag_t'(tc_rd_r[1:0]);
  assign coll = tc_rd_r[2];

  always_ff @(posedge clk) begin
    if (kv_we) kv_mem[kv_wa] <= kv_wd;
    if (tc_we) tc_mem[tc_wa] <= tc_wd;
    if (rd_en) begin
      kv_rd_r <= kv_mem[rd_addr];
      tc_rd_r <= tc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      log2_r      <= 4'(MaxLog2);
      idx_r       <= '0;
      live_r      <= '0;
      tombs_r     <= '0;
      ov_r        <= 1'b0;
      have_tomb_r <= 1'b0;
      probes_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      log2_r      <= log2_nxt;
      idx_r       <= idx_nxt;
      live_r      <= live_nxt;
      tombs_r     <= tombs_nxt;
      ov_r        <= ov_nxt;
      have_tomb_r <= have_tomb_nxt;
      probes_r    <= probes_nxt;
    end
    item_r <= item_nxt;
    step_r <= step_nxt;
    tomb_r <= tomb_nxt;
    ow_r   <= ow_nxt;
  end

  always_comb begin
    logic [HashBits-1:0] hs;
    logic                adding;
    logic                done;
    state_nxt = state_r;
    log2_nxt = log2_r;
    item_nxt = item_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    tomb_nxt = tomb_r;
    have_tomb_nxt = have_tomb_r;
    probes_nxt = probes_r;
    live_nxt = live_r;
    tombs_nxt = tombs_r;
    ov_nxt = 1'b0;
    ow_nxt = ow_r;
    rd_en = 1'b0;
    rd_addr = idx_r;
    kv_we = 1'b0;
    kv_wa = idx_r;
    kv_wd = {item_r.key, item_r.entry_value};
    tc_we = 1'b0;
    tc_wa = idx_r;
    tc_wd = {1'b0, TAG_FREE};
    adding = (item_r.command == CMD_ADD);
    hs = '0;
    done = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_word;
          state_nxt = S_READ;
          hs = in_word.key_hash >> (6'(HashBits) - 6'(lg));
          idx_nxt = IdxW'(hs) & mask;
          hs = (in_word.key_hash << lg) >> (6'(HashBits) - 6'(lg));
          step_nxt = (IdxW'(hs) | IdxW'(1)) & mask;
          have_tomb_nxt = 1'b0;
          probes_nxt = '0;
        end
      end
      S_CLEAR: begin
        // Sweep tags and collision bits, one slot a cycle.
        tc_we = 1'b1;
        idx_nxt = idx_r + IdxW'(1);
        if (idx_r == IdxW'(Slots - 1)) begin
          state_nxt = S_IDLE;
          idx_nxt = '0;
        end
      end
      S_READ: begin
        rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        probes_nxt = probes_r + CntW'(1);
        ow_nxt.slot_index = '0;
        ow_nxt.value_out = '0;
        ow_nxt.status = ST_ABSENT;
        if (tg == TAG_FREE) begin
          done = 1'b1;
          if (adding) begin
            kv_we = 1'b1;
            kv_wa = have_tomb_r ? tomb_r : idx_r;
            tc_we = 1'b1;
            tc_wa = kv_wa;
            tc_wd = {have_tomb_r ? 1'b1 : 1'b0, TAG_LIVE};
            live_nxt = live_r + CntW'(1);
            if (have_tomb_r) tombs_nxt = tombs_r - CntW'(1);
            ow_nxt.status = ST_INSERTED;
            ow_nxt.slot_index = kv_wa;
          end
        end else if (tg == TAG_LIVE && kv_rd_r[63:32] == item_r.key) begin
          done = 1'b1;
          ow_nxt.slot_index = idx_r;
          ow_nxt.value_out = kv_rd_r[31:0];
          if (item_r.command == CMD_REMOVE) begin
            ow_nxt.status = ST_REMOVED;
            tc_we = 1'b1;
            tc_wd = coll ? {1'b1, TAG_TOMB} : {1'b0, TAG_FREE};
            if (coll) tombs_nxt = tombs_r + CntW'(1);
            live_nxt = live_r - CntW'(1);
          end else if (adding) begin
            ow_nxt.status = ST_UPDATED;
            kv_we = 1'b1;
          end else begin
            ow_nxt.status = ST_FOUND;
          end
        end else begin
          if (tg == TAG_TOMB) begin
            if (!have_tomb_r) begin
              have_tomb_nxt = 1'b1;
              tomb_nxt = idx_r;
            end
          end else if (adding) begin
            tc_we = 1'b1;
            tc_wd = {1'b1, tc_rd_r[1:0]};
          end
          if (probes_r + CntW'(1) == cap) begin
            done = 1'b1;
            if (adding && have_tomb_nxt) begin
              // Reuse the first tombstone; its collision bit is kept.
              state_nxt = S_FINISH;
              done = 1'b0;
              rd_en = 1'b1;
              rd_addr = tomb_nxt;
              idx_nxt = tomb_nxt;
            end else if (adding) begin
              ow_nxt.status = ST_FULL;
            end
          end else begin
            idx_nxt = (idx_r - step_r) & mask;
            state_nxt = S_READ;
          end
        end
        if (done) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1;
          ow_nxt.live_count = live_nxt;
          ow_nxt.tombstone_count = tombs_nxt;
        end
      end
      S_FINISH: begin
        kv_we = 1'b1;
        tc_we = 1'b1;
        tc_wd = {tc_rd_r[2], TAG_LIVE};
        live_nxt = live_r + CntW'(1);
        tombs_nxt = tombs_r - CntW'(1);
        ow_nxt.status = ST_INSERTED;
        ow_nxt.slot_index = idx_r;
        ow_nxt.value_out = '0;
        ow_nxt.live_count = live_nxt;
        ow_nxt.tombstone_count = tombs_nxt;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      log2_nxt = cfg_pwdata[3:0];
      live_nxt = '0;
      tombs_nxt = '0;
      idx_nxt = '0;
      state_nxt = S_CLEAR;
    end
  end

endmodule

// ===== rtl/dhkt_checker.sv =====
// Port-level checks for the double hash key table, bound to the top level.
module dhkt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input dhkt_pkg::out_word_t out_word
);
  import dhkt_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held longer than one cycle");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status <= ST_FULL) else $error("bad status code");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.live_count + out_word.tombstone_count) <= 10'(Slots))
    else $error("counts exceed capacity");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_INSERTED || out_word.status == ST_ABSENT ||
    out_word.status == ST_FULL) |-> out_word.value_out == '0)
    else $error("value not cleared for result without value");

endmodule

bind double_hash_key_table dhkt_checker u_dhkt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);

// ===== sim/tb_double_hash_key_table.sv =====
// Self-checking testbench for the double hash key table: directed rows, then random phases.
`timescale 1ns / 1ps
module tb_double_hash_key_table;
  import dhkt_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int DrainCycles = 600;
  localparam int RandPerPhase = 225;

  typedef struct {
    bit        typed;
    out_word_t word;
  } expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  double_hash_key_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the table contents
  logic [31:0] key_mem [Slots];
  logic [31:0] val_mem [Slots];
  tag_t        tag_mem [Slots];
  bit          coll_mem [Slots];
  int unsigned live_n, tomb_n, log2_set;

  out_word_t pending_words [$];
  expect_t   row_checks [$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        no_gaps;

  function automatic void wipe_table();
    for (int i = 0; i < Slots; i++) begin
      tag_mem[i] = TAG_FREE;
      coll_mem[i] = 1'b0;
    end
    live_n = 0;
    tomb_n = 0;
  endfunction

  function automatic out_word_t probe_table(in_word_t w);
    int unsigned l, cap, mask, idx, stride, tomb_at, p, i;
    logic [31:0] shifted;
    bit hit, free_hit, seen_tomb, done, adding;
    out_word_t r;
    l = log2_set < 2 ? 2 : (log2_set > MaxLog2 ? MaxLog2 : log2_set);
    cap = 1 << l;
    mask = cap - 1;
    idx = (w.key_hash >> (HashBits - l)) & mask;
    shifted = w.key_hash << l;
    stride = ((shifted >> (HashBits - l)) | 1) & mask;
    adding = (w.command == CMD_ADD);
    hit = 0; free_hit = 0; seen_tomb = 0; done = 0; tomb_at = 0;
    r = '0;
    r.status = ST_ABSENT;
    for (int n = 0; n < cap && !done; n++) begin
      i = idx;
      if (tag_mem[i] == TAG_FREE) begin
        free_hit = 1; done = 1;
      end else if (tag_mem[i] == TAG_LIVE && key_mem[i] == w.key) begin
        hit = 1; done = 1;
      end else if (tag_mem[i] == TAG_TOMB) begin
        if (!seen_tomb) begin
          seen_tomb = 1; tomb_at = i;
        end
      end else if (adding) begin
        coll_mem[i] = 1'b1;
      end
      if (!done) idx = (idx - stride) & mask;
    end
    if (hit) begin
      r.slot_index = IdxW'(idx);
      r.value_out = val_mem[idx];
      if (w.command == CMD_REMOVE) begin
        r.status = ST_REMOVED;
        if (coll_mem[idx]) begin
          tag_mem[idx] = TAG_TOMB;
          tomb_n++;
        end else begin
          tag_mem[idx] = TAG_FREE;
        end
        live_n--;
      end else if (adding) begin
        r.status = ST_UPDATED;
        val_mem[idx] = w.entry_value;
      end else begin
        r.status = ST_FOUND;
      end
    end else if (adding) begin
      if (seen_tomb || free_hit) begin
        p = seen_tomb ? tomb_at : idx;
        if (seen_tomb) tomb_n--;
        tag_mem[p] = TAG_LIVE;
        key_mem[p] = w.key;
        val_mem[p] = w.entry_value;
        live_n++;
        r.status = ST_INSERTED;
        r.slot_index = IdxW'(p);
      end else begin
        r.status = ST_FULL;
      end
    end
    r.live_count = CntW'(live_n);
    r.tombstone_count = CntW'(tomb_n);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Predict at acceptance, check each result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      bit moved;
      moved = 1'b0;
      if (start && !busy) begin
        expect_t ex;
        out_word_t pw;
        ex = row_checks.pop_front();
        pw = probe_table(in_word);
        pending_words.push_back(ex.typed ? ex.word : pw);
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        if (pending_words.size() == 0) begin
          report("unexpected word", out_word.status, 0);
        end else begin
          out_word_t e;
          e = pending_words.pop_front();
          if (out_word.status !== e.status) report("status", out_word.status, e.status);
          if (out_word.slot_index !== e.slot_index)
            report("slot_index", out_word.slot_index, e.slot_index);
          if (out_word.value_out !== e.value_out)
            report("value_out", out_word.value_out, e.value_out);
          if (out_word.live_count !== e.live_count)
            report("live_count", out_word.live_count, e.live_count);
          if (out_word.tombstone_count !== e.tombstone_count)
            report("tombstone_count", out_word.tombstone_count, e.tombstone_count);
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(in_word_t w, bit typed, out_word_t want);
    expect_t ex;
    int g;
    ex.typed = typed;
    ex.word = want;
    row_checks.push_back(ex);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drain outstanding words and let the block fall idle
  task automatic settle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_log2(int unsigned v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_TABLE_LOG2, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    log2_set = v & 4'hf;
    wipe_table();
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic out_word_t mk(status_t s, int unsigned ix, logic [31:0] v,
                                   int unsigned lv, int unsigned tb);
    out_word_t o;
    o.status = s;
    o.slot_index = IdxW'(ix);
    o.value_out = v;
    o.live_count = CntW'(lv);
    o.tombstone_count = CntW'(tb);
    return o;
  endfunction

  function automatic in_word_t mw(cmd_t c, logic [31:0] k, logic [31:0] h, logic [31:0] v);
    in_word_t w;
    w.command = c;
    w.key = k;
    w.key_hash = h;
    w.entry_value = v;
    return w;
  endfunction

  initial begin
    int unsigned phase_log2 [8] = '{8, 3, 15, 0, 5, 2, 4, 8};
    logic [31:0] pool_key [384];
    logic [31:0] pool_hash [384];
    in_word_t    w;
    int          pool_n, r, k;

    log2_set = 8;
    wipe_table();
    no_gaps = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed rows on a four-slot table
    write_log2(2);
    while (busy) @(posedge clk);
    send(mw(CMD_LOOKUP, 1, 0, 0), 1, mk(ST_ABSENT, 0, 0, 0, 0));
    send(mw(CMD_ADD, 1, 0, 32'hffff_ffff), 1, mk(ST_INSERTED, 0, 0, 1, 0));
    send(mw(CMD_ADD, 2, 0, 0), 1, mk(ST_INSERTED, 3, 0, 2, 0));
    send(mw(CMD_LOOKUP, 2, 0, 0), 1, mk(ST_FOUND, 3, 0, 2, 0));
    send(mw(CMD_ADD, 1, 0, 5), 1, mk(ST_UPDATED, 0, 32'hffff_ffff, 2, 0));
    send(mw(CMD_REMOVE, 1, 0, 0), 1, mk(ST_REMOVED, 0, 5, 1, 1));
    send(mw(CMD_LOOKUP, 1, 0, 0), 1, mk(ST_ABSENT, 0, 0, 1, 1));
    send(mw(CMD_ADD, 3, 0, 7), 1, mk(ST_INSERTED, 0, 0, 2, 0));
    send(mw(CMD_REMOVE, 2, 0, 0), 1, mk(ST_REMOVED, 3, 0, 1, 1));
    send(mw(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678), 0, '0);
    send(mw(CMD_ADD, 10, 32'h8000_0000, 1), 0, '0);
    send(mw(CMD_ADD, 11, 32'h4000_0000, 2), 0, '0);
    send(mw(CMD_ADD, 12, 32'hc000_0000, 3), 0, '0);
    send(mw(CMD_ADD, 13, 32'h5555_5555, 4), 0, '0);
    send(mw(CMD_ADD, 14, 32'haaaa_aaaa, 5), 0, '0);
    send(mw(CMD_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 0, '0);
    send(mw(CMD_SPARE, 99, 0, 0), 0, '0);
    send(mw(CMD_REMOVE, 99, 32'h3000_0000, 0), 0, '0);
    send(mw(CMD_REMOVE, 3, 0, 0), 0, '0);
    send(mw(CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 0), 0, '0);
    settle();

    // Random phases: keys drawn from a pool so that hits, removals and full tables occur
    foreach (phase_log2[p]) begin
      int unsigned l;
      write_log2(phase_log2[p]);
      l = phase_log2[p] < 2 ? 2 : (phase_log2[p] > MaxLog2 ? MaxLog2 : phase_log2[p]);
      pool_n = (1 << l) + (1 << l) / 2;
      for (int i = 0; i < pool_n; i++) begin
        pool_key[i] = $urandom;
        pool_hash[i] = $urandom;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RandPerPhase; n++) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, pool_n - 1);
        w.command = r < 45 ? CMD_ADD : (r < 70 ? CMD_LOOKUP : (r < 95 ? CMD_REMOVE : CMD_SPARE));
        w.key = pool_key[k];
        w.key_hash = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[k];
        w.entry_value = $urandom;
        if (n % 50 == 25) no_gaps = !no_gaps;
        send(w, 0, '0);
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== double_hash_key_table.f =====
rtl/dhkt_pkg.sv
rtl/double_hash_key_table.sv
rtl/dhkt_checker.sv
sim/tb_double_hash_key_table.sv
